// ----- rtl/hcbt_pkg.sv -----
package hcbt_pkg;

   localparam int COEF_W  = 48;
   localparam int REG_W   = 14;
   localparam int ACC_W   = 64;
   localparam int BOX_W   = 32;
   localparam int CROP_W  = 16;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIVX,
      ST_DIVY,
      ST_UPD,
      ST_OUT
   } hcbt_state_type;

   typedef struct packed {
      logic       load;
      logic       acc_init;
      logic       mul_en;
      logic [2:0] term;
      logic       acc_en;
      logic [1:0] acc_sel;
      logic       div_start;
      logic       div_sel;
      logic       cap_x;
      logic       cap_y;
      logic [1:0] corner;
      logic       upd;
      logic       emit;
   } hcbt_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_busy;
      logic last;
   } hcbt_status_type;

endpackage

// ----- rtl/homography_crop_box_tracker_top.sv -----
// Homography crop-box tracker.
// Input channel req_*: one 3x3 homography per transfer, signed Q16.F coefficients,
// req_tlast marks the last homography of a sequence.
// Output channel rsp_*: one crop box per sequence, issued after the last item.
// Configuration csr_*: frame width (index 0) and height (index 1), written idle.
// Each item projects four frame corners through one shared 48x14 multiplier
// and one shared restoring divider (two quotients per corner), plus a box
// update per corner. One item is worked on at a time; req_tready is high
// only while the block is idle.
// The result sits in an output register: the next sequence is accepted and
// processed while it waits, and the block only holds before issuing another
// result if the previous one has not yet been taken.
// Reset (synchronous) clears the sequence, drops any pending result and
// restores the frame size to 1920 x 1080.
module homography_crop_box_tracker_top
   import hcbt_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // h_xx, h_xy, h_xt, h_yx, h_yy, h_yt, h_wx, h_wy, h_wt (48 bits each)
   input  logic [9*COEF_W-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // crop_left, crop_right, crop_top, crop_bottom (16 bits each)
   output logic [4*CROP_W-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [REG_W-1:0]    csr_wdata
);

   hcbt_cmd_type    cmd;
   hcbt_status_type status;

   hcbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   hcbt_dp #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a transfer while still busy");

   a_result_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result issued without returning to idle");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");
`endif

endmodule

// ----- rtl/hcbt_div.sv -----
module hcbt_div
   import hcbt_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] num,
   input  logic signed [ACC_W-1:0] den,
   output logic                    done,
   output logic signed [BOX_W-1:0] quo
);

   localparam int THR_SH = (COEF_FRAC_BITS >= 23) ? COEF_FRAC_BITS - 23 : 0;
   localparam logic [ACC_W-1:0] THR =
      (COEF_FRAC_BITS >= 23) ? (64'd1 << THR_SH) : 64'd0;

   logic [ACC_W-1:0] d_ff, d_in, rem_ff, rem_in;
   logic [31:0]      nlo_ff, nlo_in, qb_ff, qb_in;
   logic             neg_ff, neg_in, zero_ff, zero_in, ovf_ff, ovf_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic signed [BOX_W-1:0] q_ff, q_in;

   logic [ACC_W-1:0] n_mag, d_mag;
   logic [ACC_W:0]   sh, diff;
   logic             ge;
   logic [32:0]      m;

   always_comb begin
      n_mag = num[ACC_W-1] ? (64'd0 - num) : num;
      d_mag = den[ACC_W-1] ? (64'd0 - den) : den;
      sh    = {rem_ff, nlo_ff[31]};
      diff  = sh - {1'b0, d_ff};
      ge    = (sh >= {1'b0, d_ff});
      m     = ({1'b0, qb_ff} + 33'd1) >> 1;

      d_in    = d_ff;
      rem_in  = rem_ff;
      nlo_in  = nlo_ff;
      qb_in   = qb_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      q_in    = q_ff;

      if (start) begin
         d_in    = d_mag;
         rem_in  = {15'd0, n_mag[ACC_W-1:15]};
         nlo_in  = {n_mag[14:0], 17'd0};
         qb_in   = '0;
         neg_in  = num[ACC_W-1] ^ den[ACC_W-1];
         zero_in = (d_mag <= THR) || (d_mag == '0);
         ovf_in  = ({15'd0, n_mag} >= {d_mag, 15'd0});
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 6'd0) begin
            rem_in = ge ? diff[ACC_W-1:0] : sh[ACC_W-1:0];
            qb_in  = {qb_ff[30:0], ge};
            nlo_in = {nlo_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            priority if (zero_ff) begin
               q_in = '0;
            end else if (ovf_ff || m[32:31] != 2'b00) begin
               q_in = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               q_in = neg_ff ? -$signed(m[31:0]) : $signed(m[31:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      nlo_ff  <= nlo_in;
      qb_ff   <= qb_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// ----- rtl/hcbt_dp.sv -----
module hcbt_dp
   import hcbt_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hcbt_cmd_type          cmd,
   output hcbt_status_type       status,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [REG_W-1:0]      csr_wdata,
   input  logic [9*COEF_W-1:0]   req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [4*CROP_W-1:0]   rsp_tdata
);

   logic [REG_W-1:0] fw_ff, fh_ff;
   logic [REG_W-1:0] cw_ff, ch_ff, cw_in, ch_in;
   logic signed [COEF_W-1:0] h_ff [9];
   logic last_ff, open_ff, open_in;
   logic signed [ACC_W-1:0] prod_ff, acc_ff [3];
   logic signed [BOX_W-1:0] px_ff, py_ff;
   logic signed [BOX_W-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic signed [BOX_W-1:0] left_in, right_in, top_in, bottom_in;
   logic rsp_valid_ff;
   logic [4*CROP_W-1:0] rsp_data_ff;

   logic signed [COEF_W-1:0] coef;
   logic [REG_W-1:0]         coord;
   logic signed [COEF_W+REG_W:0] prod;
   logic div_done;
   logic signed [BOX_W-1:0] div_q;

   function automatic logic [CROP_W-1:0] ceil_sat(input logic signed [BOX_W-1:0] v);
      logic signed [BOX_W:0] t;
      t = ($signed({v[BOX_W-1], v}) + 33'sd65535) >>> 16;
      if (v == 32'sh8000_0000) return 16'h8001;
      if (t > 33'sd32767) return 16'h7FFF;
      return t[CROP_W-1:0];
   endfunction

   function automatic logic [CROP_W-1:0] floor_sat(input logic signed [BOX_W-1:0] v);
      logic signed [BOX_W-1:0] t;
      t = v >>> 16;
      return t[CROP_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 14'd1920;
         fh_ff <= 14'd1080;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  fw_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cw_in = (fw_ff != '0) ? fw_ff - 14'd1 : '0;
      ch_in = (fh_ff != '0) ? fh_ff - 14'd1 : '0;
      unique case (cmd.term)
         3'd0:    begin coef = h_ff[0]; coord = cmd.corner[1] ? cw_ff : '0; end
         3'd1:    begin coef = h_ff[1]; coord = cmd.corner[0] ? ch_ff : '0; end
         3'd2:    begin coef = h_ff[3]; coord = cmd.corner[1] ? cw_ff : '0; end
         3'd3:    begin coef = h_ff[4]; coord = cmd.corner[0] ? ch_ff : '0; end
         3'd4:    begin coef = h_ff[6]; coord = cmd.corner[1] ? cw_ff : '0; end
         3'd5:    begin coef = h_ff[7]; coord = cmd.corner[0] ? ch_ff : '0; end
         default: begin coef = '0;      coord = '0; end
      endcase
      prod = coef * $signed({1'b0, coord});
   end

   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      open_in   = open_ff;
      if (cmd.load && !open_ff) begin
         left_in   = '0;
         top_in    = '0;
         right_in  = $signed({2'b00, cw_in, 16'd0});
         bottom_in = $signed({2'b00, ch_in, 16'd0});
      end
      if (cmd.load) open_in = 1'b1;
      if (cmd.upd) begin
         if (!cmd.corner[1]) begin
            if (px_ff > left_ff) left_in = px_ff;
         end else if (px_ff < right_ff) begin
            right_in = px_ff;
         end
         if (!cmd.corner[0]) begin
            if (py_ff > top_ff) top_in = py_ff;
         end else if (py_ff < bottom_ff) begin
            bottom_in = py_ff;
         end
      end
      if (cmd.emit) open_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 9; i++) h_ff[i] <= req_tdata[i*COEF_W +: COEF_W];
         last_ff <= req_tlast;
         cw_ff   <= cw_in;
         ch_ff   <= ch_in;
      end
      if (cmd.mul_en) prod_ff <= ACC_W'(prod);
      if (cmd.acc_init) begin
         acc_ff[0] <= ACC_W'(h_ff[2]);
         acc_ff[1] <= ACC_W'(h_ff[5]);
         acc_ff[2] <= ACC_W'(h_ff[8]);
      end else if (cmd.acc_en) begin
         acc_ff[cmd.acc_sel] <= acc_ff[cmd.acc_sel] + prod_ff;
      end
      if (cmd.cap_x && div_done) px_ff <= div_q;
      if (cmd.cap_y && div_done) py_ff <= div_q;
      left_ff   <= left_in;
      right_ff  <= right_in;
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
      if (cmd.emit) begin
         rsp_data_ff <= {floor_sat(bottom_ff), ceil_sat(top_ff),
                         floor_sat(right_ff), ceil_sat(left_ff)};
      end
      if (reset) begin
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   hcbt_div #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num  (cmd.div_sel ? acc_ff[1] : acc_ff[0]),
      .den  (acc_ff[2]),
      .done (div_done),
      .quo  (div_q)
   );

   assign status.div_done = div_done;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign status.last     = last_ff;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

// ----- rtl/hcbt_ctrl.sv -----
module hcbt_ctrl
   import hcbt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  hcbt_status_type status,
   output hcbt_cmd_type    cmd
);

   hcbt_state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] corner_ff, corner_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      corner_in  = corner_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.corner = corner_ff;
      cmd.term   = cnt_ff;
      cmd.acc_sel = 2'((cnt_ff - 3'd1) >> 1);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               cnt_in    = '0;
               corner_in = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.acc_init = (cnt_ff == 3'd0);
            cmd.mul_en   = (cnt_ff < 3'd6);
            cmd.acc_en   = (cnt_ff != 3'd0) && (cnt_ff != 3'd7);
            // start the divide only after the last product has been summed
            if (cnt_ff == 3'd7) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVX;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DIVX: begin
            cmd.cap_x = 1'b1;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = 1'b1;
               state_in      = ST_DIVY;
            end
         end
         ST_DIVY: begin
            cmd.cap_y = 1'b1;
            if (status.div_done) state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            if (corner_ff == 2'd3) begin
               state_in = ST_OUT;
            end else begin
               corner_in = corner_ff + 2'd1;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
